// File: rtl/core/rmq_pkg.sv
// Shared types and codes for the rotation matrix to quaternion block.
package rmq_pkg;
    localparam int ELEM_W = 32;
    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic [1:0] branch_t;
    localparam branch_t BR_TRACE = 2'd0;
    localparam branch_t BR_X     = 2'd1;
    localparam branch_t BR_Y     = 2'd2;
    localparam branch_t BR_Z     = 2'd3;
endpackage

// File: rtl/core/rmq_mat_if.sv
// Matrix input channel: valid/ready handshake with nine matrix elements.
interface rmq_mat_if;
    import rmq_pkg::*;
    logic  valid;
    logic  ready;
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

// File: rtl/core/rmq_quat_if.sv
// Quaternion output channel: valid/ready handshake with result fields.
interface rmq_quat_if;
    import rmq_pkg::*;
    logic    valid;
    logic    ready;
    elem_t   quat_x;
    elem_t   quat_y;
    elem_t   quat_z;
    elem_t   quat_w;
    branch_t dominant_branch;
    logic    domain_error;
    modport source (output valid, quat_x, quat_y, quat_z, quat_w, dominant_branch,
                    domain_error, input ready);
    modport sink (input valid, quat_x, quat_y, quat_z, quat_w, dominant_branch,
                  domain_error, output ready);
endinterface

// File: rtl/core/rotation_matrix_to_quaternion.sv
// Pipelined rotation matrix to quaternion converter (Shepperd method).
//
// in_ch carries one 3x3 matrix per transaction, out_ch one quaternion with
// the branch taken and a domain error flag. All values are signed fixed
// point with FRAC_BITS fraction bits.
// The pipeline takes one transaction per cycle. Below, SW stands for
// ceil((max(FRAC_BITS,31) + FRAC_BITS + 3)/2). One stage forms the raw
// components, SW stages extract the square root one bit each, one stage
// forms the dividends, 33 stages divide the four components in parallel
// one quotient bit each, and one stage saturates, restores the sign and
// registers the result.
// The whole pipeline advances together: when out_ch stalls with a result
// waiting, every stage holds and in_ch.ready drops; nothing is lost.
// Bubbles travel as cleared valid bits.
// Reset clears all valid bits; payload registers are not reset.
// A non-positive dominant value gives zero components and domain_error.
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = 30
) (
    input logic        clk,
    input logic        rst_n,
    rmq_mat_if.sink    in_ch,
    rmq_quat_if.source out_ch
);
    import rmq_pkg::*;

    localparam int MX   = (FRAC_BITS > 31) ? FRAC_BITS : 31;
    localparam int RW   = MX + 4;            // raw component width, signed
    localparam int MW   = RW - 1;            // magnitude width
    localparam int XW   = MW + FRAC_BITS;    // radicand width
    localparam int SW   = (XW + 1) / 2;      // root width
    localparam int QB   = ELEM_W + 1;        // quotient bits kept
    localparam int NW   = MW + FRAC_BITS + 1;// dividend width
    localparam int DW   = SW + 1;            // divisor width
    localparam int LAST = SW + QB + 2;

    logic ce;
    logic v_reg [0:LAST];

    // stage 0 combinational
    logic signed [RW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
    logic signed [RW-1:0] one_c, tr, dom;
    logic signed [RW-1:0] raw [0:3];
    branch_t              br_next;

    // payload registers
    logic [MW-1:0]   mag_reg [0:SW][0:3];
    logic            neg_reg [0:SW+QB+1][0:3];
    branch_t         br_reg  [0:SW+QB+1];
    logic            err_reg [0:SW+QB+1];
    logic [2*SW-1:0] sx_reg  [0:SW-1];
    logic [SW+1:0]   sr_reg  [0:SW-1];
    logic [SW-1:0]   sq_reg  [0:SW];
    logic [DW-1:0]   dr_reg  [0:QB-1][0:3];
    logic [QB-1:0]   dn_reg  [0:QB-1][0:3];
    logic [DW-1:0]   dd_reg  [0:QB-1];
    logic [QB-1:0]   dq_reg  [0:QB][0:3];
    logic            ov_reg  [0:QB][0:3];
    elem_t           q_reg   [0:3];
    branch_t         obr_reg;
    logic            oerr_reg;

    // next values
    logic [SW+1:0]   sr_next [0:SW-1];
    logic [SW-1:0]   sq_next [0:SW-1];
    logic [NW-1:0]   num_next [0:3];
    logic [NW-1:0]   hi_next  [0:3];
    logic [DW-1:0]   dr_next [0:QB-1][0:3];
    logic [QB-1:0]   dq_next [0:QB-1][0:3];
    elem_t           q_next  [0:3];

    assign ce          = !v_reg[LAST] || out_ch.ready;
    assign in_ch.ready = ce;

    always_comb
    begin
        a00 = RW'(in_ch.m00);
        a01 = RW'(in_ch.m01);
        a02 = RW'(in_ch.m02);
        a10 = RW'(in_ch.m10);
        a11 = RW'(in_ch.m11);
        a12 = RW'(in_ch.m12);
        a20 = RW'(in_ch.m20);
        a21 = RW'(in_ch.m21);
        a22 = RW'(in_ch.m22);
        one_c = RW'(1) <<< FRAC_BITS;
        tr = a00 + a11 + a22;
        priority if (tr > 0)
        begin
            br_next = BR_TRACE;
            raw[0] = a21 - a12;
            raw[1] = a02 - a20;
            raw[2] = a10 - a01;
            raw[3] = tr + one_c;
            dom = raw[3];
        end
        else if (a00 > a11 && a00 > a22)
        begin
            br_next = BR_X;
            raw[0] = one_c + a00 - a11 - a22;
            raw[1] = a01 + a10;
            raw[2] = a02 + a20;
            raw[3] = a21 - a12;
            dom = raw[0];
        end
        else if (a11 > a22)
        begin
            br_next = BR_Y;
            raw[0] = a01 + a10;
            raw[1] = one_c + a11 - a00 - a22;
            raw[2] = a12 + a21;
            raw[3] = a02 - a20;
            dom = raw[1];
        end
        else
        begin
            br_next = BR_Z;
            raw[0] = a02 + a20;
            raw[1] = a12 + a21;
            raw[2] = one_c + a22 - a00 - a11;
            raw[3] = a10 - a01;
            dom = raw[2];
        end
    end

    // square root: one root bit per stage
    always_comb
    begin
        logic [SW+3:0] t;
        logic [SW+3:0] trial;
        for (int k = 0; k < SW; k++)
        begin
            t     = {sr_reg[k], sx_reg[k][2*SW-1 -: 2]};
            trial = (SW+4)'({sq_reg[k], 2'b01});
            if (t >= trial)
            begin
                sr_next[k] = (SW+2)'(t - trial);
                sq_next[k] = {sq_reg[k][SW-2:0], 1'b1};
            end
            else
            begin
                sr_next[k] = (SW+2)'(t);
                sq_next[k] = {sq_reg[k][SW-2:0], 1'b0};
            end
        end
    end

    // dividend: |R| * 2^F + S, overflow when quotient needs more than QB bits
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            num_next[l] = (NW'(mag_reg[SW][l]) << FRAC_BITS) + NW'(sq_reg[SW]);
            hi_next[l]  = num_next[l] >> QB;
        end
    end

    // restoring division: one quotient bit per stage, four lanes
    always_comb
    begin
        logic [DW:0] t;
        logic [DW:0] d;
        for (int j = 0; j < QB; j++)
        begin
            for (int l = 0; l < 4; l++)
            begin
                t = {dr_reg[j][l], dn_reg[j][l][QB-1]};
                d = {1'b0, dd_reg[j]};
                if (t >= d)
                begin
                    dr_next[j][l] = DW'(t - d);
                    dq_next[j][l] = {dq_reg[j][l][QB-2:0], 1'b1};
                end
                else
                begin
                    dr_next[j][l] = DW'(t);
                    dq_next[j][l] = {dq_reg[j][l][QB-2:0], 1'b0};
                end
            end
        end
    end

    // saturate and restore sign
    always_comb
    begin
        logic [QB-1:0] lim;
        logic [QB-1:0] m;
        for (int l = 0; l < 4; l++)
        begin
            lim = neg_reg[SW+QB+1][l] ? (QB'(1) << (ELEM_W-1))
                                       : ((QB'(1) << (ELEM_W-1)) - QB'(1));
            m = (ov_reg[QB][l] || dq_reg[QB][l] > lim) ? lim : dq_reg[QB][l];
            if (err_reg[SW+QB+1])
                q_next[l] = '0;
            else if (neg_reg[SW+QB+1][l])
                q_next[l] = ELEM_W'(-m);
            else
                q_next[l] = ELEM_W'(m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= LAST; i++)
                v_reg[i] <= 1'b0;
        end
        else if (ce)
        begin
            v_reg[0] <= in_ch.valid;
            for (int i = 1; i <= LAST; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            // stage 0
            for (int l = 0; l < 4; l++)
            begin
                neg_reg[0][l] <= raw[l][RW-1];
                mag_reg[0][l] <= raw[l][RW-1] ? MW'(-raw[l]) : MW'(raw[l]);
            end
            br_reg[0]  <= br_next;
            err_reg[0] <= (dom <= 0);
            sx_reg[0]  <= (2*SW)'(dom[MW-1:0]) << FRAC_BITS;
            sr_reg[0]  <= '0;
            sq_reg[0]  <= '0;

            // side information travels with the item
            for (int i = 1; i <= SW+QB+1; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
                br_reg[i]  <= br_reg[i-1];
                err_reg[i] <= err_reg[i-1];
            end
            for (int k = 1; k <= SW; k++)
                mag_reg[k] <= mag_reg[k-1];

            for (int k = 0; k < SW; k++)
                sq_reg[k+1] <= sq_next[k];
            for (int k = 0; k < SW-1; k++)
            begin
                sx_reg[k+1] <= sx_reg[k] << 2;
                sr_reg[k+1] <= sr_next[k];
            end

            // division entry
            dd_reg[0] <= {sq_reg[SW], 1'b0};
            for (int l = 0; l < 4; l++)
            begin
                ov_reg[0][l] <= hi_next[l] >= NW'({sq_reg[SW], 1'b0});
                dr_reg[0][l] <= (hi_next[l] >= NW'({sq_reg[SW], 1'b0}))
                                ? '0 : DW'(hi_next[l]);
                dn_reg[0][l] <= num_next[l][QB-1:0];
                dq_reg[0][l] <= '0;
            end
            for (int j = 0; j < QB; j++)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    dq_reg[j+1][l] <= dq_next[j][l];
                    ov_reg[j+1][l] <= ov_reg[j][l];
                end
            end
            for (int j = 0; j < QB-1; j++)
            begin
                dd_reg[j+1] <= dd_reg[j];
                for (int l = 0; l < 4; l++)
                begin
                    dr_reg[j+1][l] <= dr_next[j][l];
                    dn_reg[j+1][l] <= dn_reg[j][l] << 1;
                end
            end

            for (int l = 0; l < 4; l++)
                q_reg[l] <= q_next[l];
            obr_reg  <= br_reg[SW+QB+1];
            oerr_reg <= err_reg[SW+QB+1];
        end
    end

    assign out_ch.valid           = v_reg[LAST];
    assign out_ch.quat_x          = q_reg[0];
    assign out_ch.quat_y          = q_reg[1];
    assign out_ch.quat_z          = q_reg[2];
    assign out_ch.quat_w          = q_reg[3];
    assign out_ch.dominant_branch = obr_reg;
    assign out_ch.domain_error    = oerr_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.domain_error |->
            out_ch.quat_x == 0 && out_ch.quat_y == 0 &&
            out_ch.quat_z == 0 && out_ch.quat_w == 0)
        else $error("domain error result carries nonzero components");

    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v_reg[0])
        else $error("accepted transaction did not enter the pipeline");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !ce |=> v_reg[0] == $past(v_reg[0]) && v_reg[SW] == $past(v_reg[SW]))
        else $error("pipeline moved during an output stall");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(v_reg[LAST-1]))
        else $error("result appeared without a transaction behind it");
endmodule
